@@ rtl/core/shabs_pkg.sv @@
// Shared types and constants of the SHA-256 byte-stream hasher.
// No dependencies; every other file refers to it by scoped names.
package shabs_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    // One message-schedule word handed from the front to the back
    typedef struct packed {
        logic [31:0] word;
        logic        blk_last;
        logic        msg_last;
    } qword_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    localparam logic [7:0] PAD_MARK     = 8'h80;
    localparam logic [5:0] LEN_LIMIT    = 6'd56;
    localparam logic [3:0] LEN_HI_WORD  = 4'd14;
    localparam logic [3:0] LAST_WORD_IX = 4'd15;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

@@ rtl/core/shabs_queue.sv @@
// Short word queue between the front (packer and padder) and the back (compression).
// Depends on shabs_pkg for the entry and status types.
module shabs_queue #(
    parameter int DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  shabs_pkg::qword_t push_data,
    input  logic              pop,
    output shabs_pkg::qword_t pop_data,
    output shabs_pkg::q_stat_t stat
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    shabs_pkg::qword_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_push, do_pop;

    assign stat.full  = (cnt_reg == CNT_FULL);
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_FULL) else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.full && !pop |=> stat.full) else $error("full queue lost an entry");
    a_push_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        do_push && !do_pop |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("push not counted");
endmodule

@@ rtl/core/shabs_front.sv @@
// Front end: takes message bytes, packs them into big-endian words and
// generates the 0x80 marker, zero fill and bit length. Depends on shabs_pkg.
module shabs_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  shabs_pkg::in_item_t s_data,
    output logic                q_push,
    output shabs_pkg::qword_t   q_data,
    input  shabs_pkg::q_stat_t  q_stat
);
    typedef enum logic {ST_ACCEPT, ST_PAD} state_t;

    state_t      state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] cnt_reg, cnt_next;
    logic [31:0] acc_reg, acc_next;
    logic [3:0]  wp_reg, wp_next;
    logic        mark_done_reg, mark_done_next;
    logic        final_blk_reg, final_blk_next;

    logic        accept;
    logic [31:0] acc_ins, mark_word, pad_word;
    logic [5:0]  fill_after;
    logic [63:0] bit_len;

    assign s_ready = (state_reg == ST_ACCEPT) && !q_stat.full;
    assign accept  = s_valid && s_ready;
    assign bit_len = {cnt_reg[60:0], 3'b000};

    always_comb begin
        acc_ins = acc_reg;
        case (fill_reg[1:0])
            2'd0:    acc_ins[31:24] = s_data.data_byte;
            2'd1:    acc_ins[23:16] = s_data.data_byte;
            2'd2:    acc_ins[15:8]  = s_data.data_byte;
            default: acc_ins[7:0]   = s_data.data_byte;
        endcase
    end

    // Keep the bytes already packed, place the marker, clear the rest
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (2'(k) < fill_reg[1:0]) begin
                mark_word[31 - 8*k -: 8] = acc_reg[31 - 8*k -: 8];
            end else if (2'(k) == fill_reg[1:0]) begin
                mark_word[31 - 8*k -: 8] = shabs_pkg::PAD_MARK;
            end else begin
                mark_word[31 - 8*k -: 8] = 8'h00;
            end
        end
    end

    always_comb begin
        if (!mark_done_reg) begin
            pad_word = mark_word;
        end else if (final_blk_reg && wp_reg == shabs_pkg::LEN_HI_WORD) begin
            pad_word = bit_len[63:32];
        end else if (final_blk_reg && wp_reg == shabs_pkg::LAST_WORD_IX) begin
            pad_word = bit_len[31:0];
        end else begin
            pad_word = '0;
        end
    end

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        wp_next        = wp_reg;
        mark_done_next = mark_done_reg;
        final_blk_next = final_blk_reg;
        q_push         = 1'b0;
        q_data         = '0;
        fill_after     = fill_reg;

        unique case (state_reg)
            ST_ACCEPT: begin
                if (accept && s_data.has_byte) begin
                    acc_next   = acc_ins;
                    fill_after = fill_reg + 1'b1;
                    fill_next  = fill_after;
                    cnt_next   = cnt_reg + 1'b1;
                    if (fill_reg[1:0] == 2'd3) begin
                        q_push          = 1'b1;
                        q_data.word     = acc_ins;
                        q_data.blk_last = (fill_reg[5:2] == shabs_pkg::LAST_WORD_IX);
                        q_data.msg_last = 1'b0;
                    end
                end
                if (accept && s_data.end_of_message) begin
                    state_next     = ST_PAD;
                    wp_next        = fill_after[5:2];
                    mark_done_next = 1'b0;
                    final_blk_next = (fill_after < shabs_pkg::LEN_LIMIT);
                end
            end
            ST_PAD: begin
                if (!q_stat.full) begin
                    q_push          = 1'b1;
                    q_data.word     = pad_word;
                    q_data.blk_last = (wp_reg == shabs_pkg::LAST_WORD_IX);
                    q_data.msg_last = final_blk_reg && (wp_reg == shabs_pkg::LAST_WORD_IX);
                    mark_done_next  = 1'b1;
                    if (wp_reg == shabs_pkg::LAST_WORD_IX) begin
                        wp_next = '0;
                        if (final_blk_reg) begin
                            state_next = ST_ACCEPT;
                            fill_next  = '0;
                            cnt_next   = '0;
                        end else begin
                            final_blk_next = 1'b1;
                        end
                    end else begin
                        wp_next = wp_reg + 1'b1;
                    end
                end
            end
            default: state_next = ST_ACCEPT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_ACCEPT;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            wp_reg        <= '0;
            mark_done_reg <= 1'b0;
            final_blk_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            cnt_reg       <= cnt_next;
            wp_reg        <= wp_next;
            mark_done_reg <= mark_done_next;
            final_blk_reg <= final_blk_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_stat.full) else $error("push into full queue");
    a_msg_done: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push && q_data.msg_last |=> state_reg == ST_ACCEPT && fill_reg == '0
        && cnt_reg == '0) else $error("front not cleared after final block");
    a_msg_last_blk: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push && q_data.msg_last |-> q_data.blk_last)
        else $error("final word not at end of block");
endmodule

@@ rtl/core/shabs_back.sv @@
// Back end: gathers sixteen words, runs 64 compression rounds one per cycle,
// folds the result into the chain words and streams the digest. Depends on shabs_pkg.
module shabs_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    output logic                 q_pop,
    input  shabs_pkg::qword_t    q_data,
    input  shabs_pkg::q_stat_t   q_stat,
    output logic                 m_valid,
    input  logic                 m_ready,
    output shabs_pkg::out_item_t m_data
);
    typedef enum logic [1:0] {ST_LOAD, ST_ROUND, ST_UPDATE, ST_EMIT} state_t;

    state_t      state_reg;
    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [31:0] chain_reg [8];
    logic [5:0]  rnd_reg;
    logic        final_reg;
    logic [2:0]  idx_reg;

    logic [31:0] t1, t2, w_new;
    logic        emit_go;

    assign q_pop   = (state_reg == ST_LOAD) && !q_stat.empty;
    assign m_valid = (state_reg == ST_EMIT);
    assign emit_go = m_valid && m_ready;

    assign m_data.digest_word = chain_reg[idx_reg];
    assign m_data.word_index  = idx_reg;
    assign m_data.last_word   = (idx_reg == 3'd7);

    assign t1 = v_reg[7] + shabs_pkg::big_sigma1(v_reg[4])
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + shabs_pkg::ROUND_K[rnd_reg] + w_reg[0];
    assign t2 = shabs_pkg::big_sigma0(v_reg[0])
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    assign w_new = shabs_pkg::small_sigma1(w_reg[14]) + w_reg[9]
                 + shabs_pkg::small_sigma0(w_reg[1]) + w_reg[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            rnd_reg   <= '0;
            final_reg <= 1'b0;
            idx_reg   <= '0;
            for (int i = 0; i < 8; i++) chain_reg[i] <= shabs_pkg::INIT_H[i];
        end else begin
            unique case (state_reg)
                ST_LOAD: begin
                    if (q_pop && q_data.blk_last) begin
                        final_reg <= q_data.msg_last;
                        rnd_reg   <= '0;
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    rnd_reg <= rnd_reg + 1'b1;
                    if (rnd_reg == 6'd63) begin
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    for (int i = 0; i < 8; i++) chain_reg[i] <= chain_reg[i] + v_reg[i];
                    idx_reg   <= '0;
                    state_reg <= final_reg ? ST_EMIT : ST_LOAD;
                end
                ST_EMIT: begin
                    if (emit_go) begin
                        idx_reg <= idx_reg + 1'b1;
                        if (idx_reg == 3'd7) begin
                            for (int i = 0; i < 8; i++) chain_reg[i] <= shabs_pkg::INIT_H[i];
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

    // Schedule window and working variables: payload, no reset
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
            w_reg[15] <= q_data.word;
            if (q_data.blk_last) begin
                for (int i = 0; i < 8; i++) v_reg[i] <= chain_reg[i];
            end
        end else if (state_reg == ST_ROUND) begin
            for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    a_round_end: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ROUND && rnd_reg == 6'd63 |=> state_reg == ST_UPDATE)
        else $error("round count overrun");
    a_emit_done: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_go && m_data.last_word |=> !m_valid && chain_reg[0] == shabs_pkg::INIT_H[0])
        else $error("chain not restored after digest");
    a_no_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_LOAD |-> !q_pop) else $error("pop outside load");
endmodule

@@ rtl/core/sha256_byte_stream_hasher_top.sv @@
// channel | ports                       | accepted when
// input   | s_valid s_ready s_data      | s_valid && s_ready
// result  | m_valid m_ready m_data      | m_valid && m_ready
//
// One message byte per cycle is taken while the word queue has room and no padding is being sent.
// Each 64-byte block costs 64 compression rounds and a fold step in the back
// end; the queue holds only QUEUE_DEPTH words, so a long message stalls the
// input meanwhile. Ending a message adds up to 18 padding words.
// Reset (aresetn low, synchronous) loads the initial hash values at once.
// Stalls on m_ready hold the digest word and back up the queue to s_ready.
// Depends on shabs_pkg, shabs_front, shabs_queue and shabs_back.
module sha256_byte_stream_hasher_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  shabs_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output shabs_pkg::out_item_t m_data
);
    logic               q_push, q_pop;
    shabs_pkg::qword_t  q_in, q_out;
    shabs_pkg::q_stat_t q_stat;

    shabs_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_push  (q_push),
        .q_data  (q_in),
        .q_stat  (q_stat)
    );

    shabs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .stat      (q_stat)
    );

    shabs_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_pop   (q_pop),
        .q_data  (q_out),
        .q_stat  (q_stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );
endmodule

@@ tb/sha256_byte_stream_hasher_top_tb.sv @@
// Self-checking testbench for the SHA-256 byte-stream hasher: drives message items,
// predicts the digest words with its own SHA-256 model and checks each result item.
// Depends on shabs_pkg and sha256_byte_stream_hasher_top.
module sha256_byte_stream_hasher_top_tb;

    localparam int N_DIRECTED = 12;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    shabs_pkg::in_item_t  s_data;
    logic                 m_valid;
    logic                 m_ready;
    shabs_pkg::out_item_t m_data;

    sha256_byte_stream_hasher_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // hashing state of the predictor
    logic [31:0] chain_h [8];
    logic [7:0]  blk_bytes [64];
    int          blk_fill;
    logic [63:0] msg_len;
    shabs_pkg::out_item_t digest_q [$];
    int          n_err = 0;
    int          n_dir_err = 0;
    int          send_idle_pct;
    int          recv_stall_pct;

    // directed rows: byte, has_byte, end; first word typed in where known
    typedef struct {
        logic [7:0]  b;
        logic        hb;
        logic        eom;
        logic        known;
        logic [31:0] w0;
    } dir_row_t;
    dir_row_t dir_rows [N_DIRECTED];

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #100000000;
        $display("sha256_byte_stream_hasher_top_tb NOT OK");
        $finish;
    end

    function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic void clear_hash();
        chain_h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        foreach (blk_bytes[i]) blk_bytes[i] = 8'h00;
        blk_fill = 0;
        msg_len = '0;
    endfunction

    function automatic void compress_blk();
        logic [31:0] w [64];
        logic [31:0] r [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
                 + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
        r = chain_h;
        for (int i = 0; i < 64; i++) begin
            t1 = r[7] + (ror32(r[4], 6) ^ ror32(r[4], 11) ^ ror32(r[4], 25))
               + ((r[4] & r[5]) ^ (~r[4] & r[6])) + shabs_pkg::ROUND_K[i] + w[i];
            t2 = (ror32(r[0], 2) ^ ror32(r[0], 13) ^ ror32(r[0], 22))
               + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
            r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
            r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain_h[i] += r[i];
    endfunction

    // advance the predictor by one accepted item, queue any digest words
    function automatic void hash_item(input shabs_pkg::in_item_t it);
        logic [63:0] bits;
        shabs_pkg::out_item_t o;
        if (it.has_byte) begin
            blk_bytes[blk_fill] = it.data_byte;
            msg_len++;
            blk_fill++;
            if (blk_fill == 64) begin
                compress_blk();
                blk_fill = 0;
            end
        end
        if (!it.end_of_message) return;
        blk_bytes[blk_fill] = 8'h80;
        for (int i = blk_fill + 1; i < 64; i++) blk_bytes[i] = 8'h00;
        if (blk_fill >= 56) begin
            compress_blk();
            foreach (blk_bytes[i]) blk_bytes[i] = 8'h00;
        end
        bits = msg_len << 3;
        for (int i = 0; i < 8; i++) blk_bytes[63-i] = bits[8*i +: 8];
        compress_blk();
        for (int i = 0; i < 8; i++) begin
            o.digest_word = chain_h[i];
            o.word_index = 3'(i);
            o.last_word = (i == 7);
            digest_q.push_back(o);
        end
        clear_hash();
    endfunction

    // called at a falling edge; valid stays high after acceptance until the next item or a pause
    task automatic send_item(input shabs_pkg::in_item_t it);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        end
        s_data <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        hash_item(it);
        @(negedge aclk);
    endtask

    task automatic send_message(input int len, input logic idle_noise);
        shabs_pkg::in_item_t it;
        for (int i = 0; i < len; i++) begin
            if (idle_noise && $urandom_range(9) == 0) begin
                it.data_byte = 8'($urandom);
                it.has_byte = 1'b0;
                it.end_of_message = 1'b0;
                send_item(it);
            end
            it.data_byte = 8'($urandom);
            it.has_byte = 1'b1;
            it.end_of_message = (i == len - 1);
            send_item(it);
        end
        if (len == 0) begin
            it.data_byte = 8'($urandom);
            it.has_byte = 1'b0;
            it.end_of_message = 1'b1;
            send_item(it);
        end
    endtask

    // drop valid and hold off until every expected digest item has come
    task automatic drain_digests();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        while (digest_q.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
    endtask

    // receiver: stall at random, check each accepted item against the oldest expectation
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        shabs_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (digest_q.size() == 0) begin
                n_err++;
                if (n_err + n_dir_err <= 10) $display("unexpected digest item %h", m_data);
            end else begin
                want = digest_q.pop_front();
                if (m_data.digest_word !== want.digest_word
                        || m_data.word_index !== want.word_index
                        || m_data.last_word !== want.last_word) begin
                    n_err++;
                    if (n_err + n_dir_err <= 10)
                        $display("digest mismatch: want %h/%0d/%0d got %h/%0d/%0d",
                                 want.digest_word, want.word_index, want.last_word,
                                 m_data.digest_word, m_data.word_index, m_data.last_word);
                end
            end
        end
    end

    initial begin
        int                   len;
        shabs_pkg::in_item_t  it;
        shabs_pkg::out_item_t first_w;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        clear_hash();
        // empty message, "abc", then extremes and an idle item in between
        dir_rows[0] = '{8'h00, 1'b0, 1'b1, 1'b1, 32'he3b0c442};
        dir_rows[1] = '{8'h61, 1'b1, 1'b0, 1'b0, 32'h0};
        dir_rows[2] = '{8'h62, 1'b1, 1'b0, 1'b0, 32'h0};
        dir_rows[3] = '{8'h55, 1'b0, 1'b0, 1'b0, 32'h0};
        dir_rows[4] = '{8'h63, 1'b1, 1'b1, 1'b1, 32'hba7816bf};
        dir_rows[5] = '{8'hff, 1'b1, 1'b1, 1'b0, 32'h0};
        dir_rows[6] = '{8'h00, 1'b1, 1'b1, 1'b0, 32'h0};
        dir_rows[7] = '{8'hff, 1'b1, 1'b0, 1'b0, 32'h0};
        dir_rows[8] = '{8'hff, 1'b0, 1'b1, 1'b0, 32'h0};
        dir_rows[9] = '{8'hff, 1'b0, 1'b0, 1'b0, 32'h0};
        dir_rows[10] = '{8'h00, 1'b1, 1'b0, 1'b0, 32'h0};
        dir_rows[11] = '{8'haa, 1'b1, 1'b1, 1'b0, 32'h0};
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_rows[i]) begin
            it.data_byte = dir_rows[i].b;
            it.has_byte = dir_rows[i].hb;
            it.end_of_message = dir_rows[i].eom;
            send_item(it);
            if (dir_rows[i].known) begin
                first_w = digest_q[digest_q.size() - 8];
                if (first_w.digest_word !== dir_rows[i].w0) begin
                    n_dir_err++;
                    if (n_err + n_dir_err <= 10)
                        $display("row %0d: digest word 0 want %h got %h",
                                 i, dir_rows[i].w0, first_w.digest_word);
                end
            end
        end
        // padding edges: length word just fits, just spills, and an exact block
        send_message(55, 1'b0);
        send_message(56, 1'b0);
        send_message(64, 1'b0);
        drain_digests();

        // random short messages over the idling phases
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 33 : 79) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 33 : 79) : 0;
            for (int m = 0; m < 2; m++) begin
                len = $urandom_range(8);
                send_message(len, 1'b1);
            end
            // hold off until every digest has come
            drain_digests();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (200) @(posedge aclk);
        if (n_err == 0 && n_dir_err == 0 && digest_q.size() == 0) begin
            $display("sha256_byte_stream_hasher_top_tb OK");
        end else begin
            $display("sha256_byte_stream_hasher_top_tb NOT OK");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/core/shabs_pkg.sv
rtl/core/shabs_queue.sv
rtl/core/shabs_front.sv
rtl/core/shabs_back.sv
rtl/core/sha256_byte_stream_hasher_top.sv
tb/sha256_byte_stream_hasher_top_tb.sv
